/* src/spm_pkg.sv */
package spm_pkg;

	// default and upper bound of the pattern window
	localparam int MaxPatternDefault = 16;
	localparam int PatternBytesMax   = 16;

	// configuration register file
	localparam int CfgDataW  = 64;
	localparam int CfgIndexW = 2;
	localparam int LenW      = 5;

	localparam logic [CfgIndexW-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [CfgIndexW-1:0] REG_EXACT_CASE     = 2'd3;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

	// fold ascii upper case to lower when the compare is case blind
	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic case_sens);
		logic [7:0] r;
		r = c;
		if (!case_sens && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + ASCII_CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

/* src/spm_match.sv */
module spm_match #(
	parameter int MAX_PATTERN = spm_pkg::MaxPatternDefault,
	parameter int CNT_W = $clog2(MAX_PATTERN + 1),
	parameter int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  logic [7:0]                      window [MAX_PATTERN],
	input  logic [8*spm_pkg::PatternBytesMax-1:0] pattern,
	input  logic [CNT_W-1:0]                pat_len,
	input  logic                            exact_case,
	output logic                            match
);

	logic [MAX_PATTERN-1:0] lane_ok;

	// one lane per pattern byte; pattern byte j lines up with window age len-1-j
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
		logic [CNT_W-1:0] age;
		logic [7:0]       txt;
		logic [7:0]       pat;
		assign age = pat_len - CNT_W'(1) - CNT_W'(j);
		assign txt = spm_pkg::fold_byte(window[age[IDX_W-1:0]], exact_case);
		assign pat = spm_pkg::fold_byte(pattern[8*j +: 8], exact_case);
		assign lane_ok[j] = (CNT_W'(j) >= pat_len) || (txt == pat);
	end

	assign match = &lane_ok;

endmodule

/* src/substring_presence_matcher_top.sv */
// Streaming substring detector. One text byte is taken per transfer and one
// result comes back per byte: found is high once the configured pattern (up to
// MAX_PATTERN bytes, case blind on ASCII letters when the exact-case register is
// 0) has appeared anywhere in the text so far, including the current byte; an
// empty pattern always reports found. is_last echoes end_of_text, and after that
// byte the window, count and found flag clear for the next text. Throughput is
// one byte per clock while the result side is ready: the whole window is
// compared against the pattern in parallel in a single stage, and a byte passes
// through the input register, then the result register, before its result is
// valid. Write the configuration registers only while no text is in flight.
module substring_presence_matcher_top #(
	parameter int MAX_PATTERN = spm_pkg::MaxPatternDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write,
	input  logic [spm_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [spm_pkg::CfgDataW-1:0]   cfg_data,
	// text channel
	input  logic                           text_valid,
	output logic                           text_ready,
	input  logic [7:0]                     text_byte,
	input  logic                           end_of_text,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           found,
	output logic                           is_last
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	// configuration registers
	logic [spm_pkg::CfgDataW-1:0] pat_low_q;
	logic [spm_pkg::CfgDataW-1:0] pat_high_q;
	logic [spm_pkg::LenW-1:0]     pat_len_q;
	logic                         case_sens_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// search state
	logic [7:0]       win_q [MAX_PATTERN];
	logic [7:0]       win_nx [MAX_PATTERN];
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_nx;
	logic             found_flag_q;
	logic             found_nx;

	// result register
	logic res_valid_q;
	logic res_found_q;
	logic res_last_q;

	logic             advance;
	logic             text_xfer;
	logic [CNT_W-1:0] len_eff;
	logic             match;

	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign text_ready = !valid_s1 || advance;
	assign text_xfer  = text_valid && text_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			pat_len_q   <= '0;
			case_sens_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				spm_pkg::REG_PATTERN_LOW:    pat_low_q   <= cfg_data;
				spm_pkg::REG_PATTERN_HIGH:   pat_high_q  <= cfg_data;
				spm_pkg::REG_PATTERN_LENGTH: pat_len_q   <= cfg_data[spm_pkg::LenW-1:0];
				spm_pkg::REG_EXACT_CASE:     case_sens_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pattern length clipped to the window size
	assign len_eff = (pat_len_q > spm_pkg::LenW'(MAX_PATTERN)) ?
		CNT_W'(MAX_PATTERN) : CNT_W'(pat_len_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_xfer) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	// window with the new byte shifted in at age zero
	always_comb begin
		win_nx[0] = byte_s1;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_nx[i] = win_q[i-1];
		end
	end

	assign seen_nx = (seen_q < CNT_W'(MAX_PATTERN)) ? seen_q + CNT_W'(1) : seen_q;

	spm_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.window    (win_nx),
		.pattern   ({pat_high_q, pat_low_q}),
		.pat_len   (len_eff),
		.exact_case(case_sens_q),
		.match     (match)
	);

	assign found_nx = found_flag_q || (len_eff == '0) || ((seen_nx >= len_eff) && match);

	// search state update, cleared after the last byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
			seen_q       <= '0;
			found_flag_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				for (int i = 0; i < MAX_PATTERN; i++) begin
					win_q[i] <= '0;
				end
				seen_q       <= '0;
				found_flag_q <= 1'b0;
			end else begin
				win_q        <= win_nx;
				seen_q       <= seen_nx;
				found_flag_q <= found_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_found_q <= found_nx;
			res_last_q  <= last_s1;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = res_found_q;
	assign is_last      = res_last_q;

`ifndef SYNTHESIS
	// state is clear after the last byte of a text
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> seen_q == '0 && !found_flag_q)
		else $error("search state not cleared after end of text");

	// a flagged match stays reported for the rest of the text
	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && found_flag_q |=> res_found_q)
		else $error("found flag lost within a text");

	// an empty pattern always matches
	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pat_len_q == '0 |=> res_found_q)
		else $error("empty pattern did not report found");

	// a held result is never overwritten
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result_ready |-> !advance)
		else $error("result overwritten while stalled");

	// byte count never passes the window size
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(MAX_PATTERN))
		else $error("byte count out of range");
`endif

endmodule

/* test/spm_match_checker.sv */
module spm_match_checker #(
	parameter int MAX_PATTERN = spm_pkg::MaxPatternDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [spm_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [spm_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          text_valid,
	input  logic                          text_ready,
	input  logic [7:0]                    text_byte,
	input  logic                          end_of_text,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          found,
	input  logic                          is_last,
	output int                            errors,
	output int                            pending
);

	localparam int WindowCap = (MAX_PATTERN > spm_pkg::PatternBytesMax) ?
		spm_pkg::PatternBytesMax : MAX_PATTERN;

	typedef struct packed {
		logic found;
		logic is_last;
	} verdict_t;

	// shadow of the register file
	logic [127:0] pattern_bytes;
	logic [spm_pkg::LenW-1:0] pattern_len;
	logic         exact_case;

	// text state, newest byte in slot 0
	logic [7:0] window [spm_pkg::PatternBytesMax];
	int         seen;
	logic       hit;

	// verdicts predicted but not yet transferred out
	verdict_t verdicts_due [$];

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// ascii upper case folds to lower only in case blind mode
	function automatic logic [7:0] case_folded(input logic [7:0] c);
		if (!exact_case && c >= spm_pkg::ASCII_UPPER_A && c <= spm_pkg::ASCII_UPPER_Z) begin
			return c + spm_pkg::ASCII_CASE_OFFSET;
		end
		return c;
	endfunction

	task automatic clear_text();
		int k;
		for (k = 0; k < spm_pkg::PatternBytesMax; k++) begin
			window[k] = 8'h00;
		end
		seen = 0;
		hit  = 1'b0;
	endtask

	// shift the byte in, compare the newest bytes against the pattern
	task automatic absorb_text_byte(input logic [7:0] b, input logic last, output verdict_t v);
		int   n;
		int   j;
		logic same;
		for (j = spm_pkg::PatternBytesMax - 1; j > 0; j--) begin
			window[j] = window[j-1];
		end
		window[0] = b;
		if (seen < WindowCap) begin
			seen++;
		end
		n = (pattern_len > WindowCap) ? WindowCap : int'(pattern_len);
		if (n == 0) begin
			hit = 1'b1;
		end else if (seen >= n) begin
			same = 1'b1;
			for (j = 0; j < n; j++) begin
				if (case_folded(window[n-1-j]) != case_folded(pattern_bytes[j*8 +: 8])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				hit = 1'b1;
			end
		end
		v.found   = hit;
		v.is_last = last;
		if (last) begin
			clear_text();
		end
	endtask

	// watch register writes and both channels
	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			pattern_bytes = '0;
			pattern_len   = '0;
			exact_case    = 1'b1;
			clear_text();
			verdicts_due.delete();
			pending <= 0;
		end else begin
			// register write
			if (cfg_write) begin
				case (cfg_index)
					spm_pkg::REG_PATTERN_LOW: begin
						pattern_bytes[63:0] = cfg_data;
					end
					spm_pkg::REG_PATTERN_HIGH: begin
						pattern_bytes[127:64] = cfg_data;
					end
					spm_pkg::REG_PATTERN_LENGTH: begin
						pattern_len = cfg_data[spm_pkg::LenW-1:0];
					end
					spm_pkg::REG_EXACT_CASE: begin
						exact_case = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			// result transfer against the oldest prediction
			if (result_valid && result_ready) begin
				got.found   = found;
				got.is_last = is_last;
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("result found=%b is_last=%b with nothing due",
						got.found, got.is_last));
				end else begin
					want = verdicts_due.pop_front();
					if (got.found !== want.found) begin
						report_mismatch($sformatf("found is %b, predicted %b",
							got.found, want.found));
					end
					if (got.is_last !== want.is_last) begin
						report_mismatch($sformatf("is_last is %b, predicted %b",
							got.is_last, want.is_last));
					end
				end
			end
			// text transfer
			if (text_valid && text_ready) begin
				absorb_text_byte(text_byte, end_of_text, want);
				verdicts_due.push_back(want);
			end
			pending <= verdicts_due.size();
		end
	end

endmodule

/* test/tb_substring_presence_matcher_top.sv */
module tb_substring_presence_matcher_top;

	localparam int CycleLimit = 200000;
	localparam int HoldOffCycles = 80;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_write = 1'b0;
	logic [spm_pkg::CfgIndexW-1:0] cfg_index = spm_pkg::REG_PATTERN_LOW;
	logic [spm_pkg::CfgDataW-1:0]  cfg_data = '0;
	logic                          text_valid = 1'b0;
	logic                          text_ready;
	logic [7:0]                    text_byte = 8'h00;
	logic                          end_of_text = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic                          found;
	logic                          is_last;

	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;
	int cycle_count = 0;

	// pattern currently loaded and the text being built
	logic [127:0] cur_pattern = '0;
	int           cur_len = 0;
	logic [7:0]   text_buf [$];

	substring_presence_matcher_top DUT (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.text_valid,
		.text_ready,
		.text_byte,
		.end_of_text,
		.result_valid,
		.result_ready,
		.found,
		.is_last
	);

	spm_match_checker match_check (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.text_valid,
		.text_ready,
		.text_byte,
		.end_of_text,
		.result_valid,
		.result_ready,
		.found,
		.is_last,
		.errors,
		.pending
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_cycles;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				for (hold_cycles = 0; hold_cycles < HoldOffCycles; hold_cycles++) begin
					result_ready <= 1'b0;
					@(posedge clk);
				end
				stall_request = 1'b0;
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// letters and their neighbors around the case fold boundaries
	function automatic logic [7:0] pick_letter();
		case ($urandom_range(9))
			0: return 8'h41;
			1: return 8'h61;
			2: return 8'h42;
			3: return 8'h62;
			4: return 8'h5A;
			5: return 8'h7A;
			6: return 8'h40;
			7: return 8'h5B;
			8: return 8'h60;
			default: return 8'h7B;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		end_of_text <= last;
		do @(posedge clk); while (!text_ready);
	endtask

	// wait until every predicted result has been transferred
	task automatic drain();
		text_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [spm_pkg::CfgIndexW-1:0] idx,
			input logic [spm_pkg::CfgDataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// new pattern, length and case mode; junk in the unused register bits
	task automatic choose_config(input int round);
		int          k;
		int          len;
		logic [63:0] fill;
		cur_pattern = {$urandom, $urandom, $urandom, $urandom};
		case (round)
			0: len = 16;
			1: len = 0;
			2: len = $urandom_range(17, 31);
			default: len = $urandom_range(1, 16);
		endcase
		for (k = 0; k < 16; k++) begin
			if ($urandom_range(9) < 7) begin
				cur_pattern[k*8 +: 8] = pick_letter();
			end
		end
		cur_len = (len > 16) ? 16 : len;
		fill = {$urandom, $urandom};
		drain();
		write_reg(spm_pkg::REG_PATTERN_LOW, cur_pattern[63:0]);
		write_reg(spm_pkg::REG_PATTERN_HIGH, cur_pattern[127:64]);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, {fill[63:spm_pkg::LenW], spm_pkg::LenW'(len)});
		write_reg(spm_pkg::REG_EXACT_CASE, {fill[63:1], 1'($urandom_range(1))});
	endtask

	// random filler with the pattern planted, sometimes cut short
	task automatic build_text();
		int         total;
		int         at;
		int         cut;
		int         k;
		logic [7:0] b;
		text_buf.delete();
		total = $urandom_range(1, 30);
		for (k = 0; k < total; k++) begin
			text_buf.push_back($urandom_range(1) ? pick_letter() : 8'($urandom));
		end
		if (cur_len > 0 && $urandom_range(9) < 7) begin
			cut = ($urandom_range(3) == 0) ? $urandom_range(0, cur_len - 1) : cur_len;
			at  = $urandom_range(0, total - 1);
			for (k = 0; k < cut; k++) begin
				b = cur_pattern[k*8 +: 8];
				// flip the case of some letters
				if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
						&& $urandom_range(3) == 0) begin
					b = b ^ 8'h20;
				end
				if (at + k < text_buf.size()) begin
					text_buf[at + k] = b;
				end else begin
					text_buf.push_back(b);
				end
			end
		end
	endtask

	task automatic send_text();
		int k;
		for (k = 0; k < text_buf.size(); k++) begin
			send_byte(text_buf[k], k == text_buf.size() - 1);
		end
	endtask

	initial begin : stimulus
		int phase;
		int round;
		int k;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern after reset reports found on every byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// two byte pattern "Ab", case blind
		drain();
		write_reg(spm_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_6241);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd2);
		write_reg(spm_pkg::REG_EXACT_CASE, 64'd0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h42, 1'b1);

		// exact compare: "ab" misses, "Ab" hits
		drain();
		write_reg(spm_pkg::REG_EXACT_CASE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h62, 1'b1);

		// full width pattern of all-ones and zero bytes
		drain();
		write_reg(spm_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(spm_pkg::REG_PATTERN_HIGH, 64'h0000_0000_0000_0000);
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
		for (k = 0; k < 8; k++) begin
			send_byte(8'hFF, 1'b0);
		end
		for (k = 0; k < 7; k++) begin
			send_byte(8'h00, 1'b0);
		end
		// length change inside the text, over the cap
		drain();
		write_reg(spm_pkg::REG_PATTERN_LENGTH, 64'd31);
		send_byte(8'h00, 1'b1);

		// random texts under three idle mixes
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (round = 0; round < 6; round++) begin
				choose_config(round);
				// long result hold-off while a long text keeps coming
				if (round == 0 && phase != 1) begin
					stall_request = 1'b1;
					build_text();
					while (text_buf.size() < 48) begin
						text_buf.push_back(8'($urandom));
					end
					send_text();
				end
				repeat (5) begin
					build_text();
					send_text();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/spm_pkg.sv
src/spm_match.sv
src/substring_presence_matcher_top.sv
test/spm_match_checker.sv
test/tb_substring_presence_matcher_top.sv
